[sv/smm_pkg.sv]
// shared types and constants for the square matrix multiply block
`default_nettype none

package smm_pkg;

    localparam int ELEM_W = 32;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

[sv/square_matrix_multiply.sv]
// square matrix multiply: operand memories, multiply-accumulate pipeline and result register
`default_nettype none

// Loads the elements of two MATRIX_DIM x MATRIX_DIM signed fixed point matrices A and B, one
// word per cycle while the input is not stalled, into two single-port-read memories. A word with
// compute set first stores its element, then the block sends out every element of A*B in
// row-major order, each sum taken exactly, floor-shifted by FRACTION_BITS and saturated to 32
// bits, with the last one marked. A compute word holds the input stalled while the
// MATRIX_DIM*MATRIX_DIM product elements are worked out, also through output stalls: a
// single 32x32 multiply-accumulate unit takes one term per cycle from one read port of each
// operand memory and works one product element at a time through its read, multiply and
// accumulate stages. A load word may be taken while the final result still waits to be taken.
// Elements read before being written give undefined results.
module square_matrix_multiply #(
    parameter int MATRIX_DIM    = 5,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_target_matrix,
    input  wire logic [smm_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [smm_pkg::IDX_W-1:0]         i_column_index,
    input  wire logic signed [smm_pkg::ELEM_W-1:0] i_element_value,
    input  wire logic                              i_compute_now,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [smm_pkg::IDX_W-1:0]              o_result_row,
    output logic [smm_pkg::IDX_W-1:0]              o_result_column,
    output logic signed [smm_pkg::ELEM_W-1:0]      o_product_value,
    output logic                                   o_saturated,
    output logic                                   o_last_result
);
    import smm_pkg::*;

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int AW     = $clog2(CELLS);
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM);
    localparam int MUL_W  = 2 * IDX_W;
    localparam logic [IDX_W:0]   DIM_L  = (IDX_W + 1)'(MATRIX_DIM);
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(MATRIX_DIM - 1);
    localparam logic [MUL_W-1:0] DIM_M  = MUL_W'(MATRIX_DIM);

    // operand memories
    logic signed [ELEM_W-1:0] r_mem_a [CELLS];
    logic signed [ELEM_W-1:0] r_mem_b [CELLS];
    logic signed [ELEM_W-1:0] r_a_q;
    logic signed [ELEM_W-1:0] r_b_q;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;

    logic             w_in_acc;
    logic             w_in_range;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_a_addr;
    logic [AW-1:0]    w_rd_b_addr;
    logic             w_issue;
    logic             w_land;
    logic             w_out_free;
    logic             w_last_elem;

    // pipeline control
    logic r_s1_valid, r_s1_first, r_s1_last;
    logic r_s2_valid, r_s2_first, r_s2_last;
    logic r_s3_valid, r_s3_last;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_shifted;
    logic                     w_fits;

    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row;
    logic [IDX_W-1:0]         r_out_col;
    logic signed [ELEM_W-1:0] r_out_value;
    logic                     r_out_sat;
    logic                     r_out_last;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_row_index} < DIM_L) && ({1'b0, i_column_index} < DIM_L);

    assign w_wr_addr   = AW'({{IDX_W{1'b0}}, i_row_index} * DIM_M) + AW'(i_column_index);
    assign w_rd_a_addr = AW'({{IDX_W{1'b0}}, r_row} * DIM_M) + AW'(r_k);
    assign w_rd_b_addr = AW'({{IDX_W{1'b0}}, r_k} * DIM_M) + AW'(r_col);

    assign w_issue     = (r_state == ST_ISSUE);
    assign w_land      = r_s3_valid && r_s3_last;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_last_elem = (r_row == LAST_I) && (r_col == LAST_I);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_in_range && !i_target_matrix) begin
            r_mem_a[w_wr_addr] <= i_element_value;
        end
        r_a_q <= r_mem_a[w_rd_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_in_range && i_target_matrix) begin
            r_mem_b[w_wr_addr] <= i_element_value;
        end
        r_b_q <= r_mem_b[w_rd_b_addr];
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_compute_now) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // nothing else fills the result register, so once free it stays free
                if (w_out_free) begin
                    n_k     = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_k == LAST_I) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (w_land) begin
                    if (w_last_elem) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_WAIT;
                        if (r_col == LAST_I) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    // read, multiply, accumulate
    assign w_prod_ext = $signed({{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == LAST_I);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s3_last  <= r_s2_last;
        r_prod     <= r_a_q * r_b_q;
        if (r_s2_valid) begin
            r_acc <= r_s2_first ? w_prod_ext : r_acc + w_prod_ext;
        end
    end

    // floor shift, then clip to 32 bits
    assign w_shifted = r_acc >>> FRACTION_BITS;
    assign w_fits    = (&w_shifted[ACC_W-1:ELEM_W-1]) || !(|w_shifted[ACC_W-1:ELEM_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_land) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_land) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_sat  <= !w_fits;
            r_out_last <= w_last_elem;
            if (w_fits) begin
                r_out_value <= w_shifted[ELEM_W-1:0];
            end else if (w_shifted[ACC_W-1]) begin
                r_out_value <= {1'b1, {(ELEM_W - 1){1'b0}}};
            end else begin
                r_out_value <= {1'b0, {(ELEM_W - 1){1'b1}}};
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_row    = r_out_row;
    assign o_result_column = r_out_col;
    assign o_product_value = r_out_value;
    assign o_saturated     = r_out_sat;
    assign o_last_result   = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_land |-> w_out_free)
        else $error("result lands on an untaken word");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid || r_s2_valid || r_s3_valid) |-> o_in_stall)
        else $error("input open while a sum is in flight");

    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ($past(r_state) == ST_ISSUE))
        else $error("read issued outside the issue state");

    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |->
            ((o_result_row == LAST_I) && (o_result_column == LAST_I)))
        else $error("last flag on a wrong element");
`endif

endmodule

`default_nettype wire
